### hdl/tlvlp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// TLV label patcher package
// Word types, register indexes, scan constants and label byte selection.
// ----------------------------------------------------------------------------
package tlvlp_pkg;

	localparam int LABEL_BYTES_DEF = 16;
	localparam int HOLD_DEPTH      = 16;
	localparam int HOLD_AW         = 4;

	localparam logic [63:0] LABEL_RESET = 64'h2020_2020_2020_2020;

	// Configuration register indexes.
	localparam logic CFG_LABEL_LOW  = 1'b0;
	localparam logic CFG_LABEL_HIGH = 1'b1;

	localparam logic [7:0] LABEL_KIND = 8'h06;
	localparam logic [7:0] MAGIC_H    = 8'h48;
	localparam logic [7:0] MAGIC_O    = 8'h4F;
	localparam logic [7:0] MAGIC_B    = 8'h42;
	localparam logic [7:0] MAGIC_C    = 8'h43;
	localparam logic [7:0] MAGIC_VER  = 8'h01;
	localparam logic [2:0] MAGIC_LAST = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_flag;
		logic       last_flag;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_flag;
		logic [7:0] patch_count;
	} out_word_t;

	// Expected byte at a given position of the magic.
	function automatic logic [7:0] magic_byte(input logic [2:0] pos);
		logic [7:0] r;
		case (pos)
			3'd0:    r = MAGIC_H;
			3'd1:    r = MAGIC_O;
			3'd2:    r = MAGIC_B;
			3'd3:    r = MAGIC_C;
			default: r = MAGIC_VER;
		endcase
		return r;
	endfunction

	// Label byte k: bytes 0..7 come from the low word, 8..15 from the high word.
	function automatic logic [7:0] label_byte(input logic [63:0] lo, input logic [63:0] hi,
		input logic [HOLD_AW-1:0] k);
		logic [7:0] r;
		if (k[3]) begin
			r = hi[{k[2:0], 3'b000} +: 8];
		end else begin
			r = lo[{k[2:0], 3'b000} +: 8];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hdl/tlv_marker_label_patcher_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// TLV marker label patcher core
// Scans a byte stream for the magic, walks the records after it and replaces
// the value of each label record with the configured label.
// ----------------------------------------------------------------------------
// The block takes one buffer byte per word on in_data and returns the buffer
// on out_data, one byte per word and in order. A plain stream flows at one word
// per cycle in both directions while out_ready is high. The value bytes of a
// label record (type 6, length LABEL_BYTES) produce no output while they
// arrive; they are written into a 16-entry hold memory. The last value byte
// then starts a burst of LABEL_BYTES label words, one per cycle while out_ready
// is high, taken from the label registers. If the buffer ends inside such a
// value, a flush burst reads the hold memory back one entry per cycle while
// out_ready is high and emits the held bytes plus the final byte unchanged,
// fill + 1 words in all. During a burst one further input word is buffered,
// then in_ready drops until the burst has drained. The final word of a buffer
// carries end_flag and the count of patched records; patch_count reads zero on
// other words. Label registers are written through cfg_we, cfg_index and
// cfg_data and should only be changed while the block is idle.
// ----------------------------------------------------------------------------
module tlv_marker_label_patcher_core #(
	parameter int LABEL_BYTES = tlvlp_pkg::LABEL_BYTES_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire tlvlp_pkg::in_word_t in_data,
	output logic                  out_valid,
	input  wire                   out_ready,
	output tlvlp_pkg::out_word_t  out_data,
	input  wire                   cfg_we,
	input  wire                   cfg_index,
	input  wire  [63:0]           cfg_data
);

	localparam int AW = tlvlp_pkg::HOLD_AW;

	// Walk phases.
	localparam logic [1:0] PH_SEARCH = 2'd0;
	localparam logic [1:0] PH_TYPE   = 2'd1;
	localparam logic [1:0] PH_LEN    = 2'd2;
	localparam logic [1:0] PH_VALUE  = 2'd3;

	localparam logic [7:0]    LABEL_LEN  = 8'(LABEL_BYTES);
	localparam logic [AW-1:0] LABEL_LAST = AW'(LABEL_BYTES - 1);

	// Label registers.
	logic [63:0] label_lo_q;
	logic [63:0] label_hi_q;

	// Input buffer word.
	logic                 pend_valid_q;
	tlvlp_pkg::in_word_t  pend_q;

	// Scan state.
	logic [2:0]    magic_q;
	logic [1:0]    phase_q;
	logic          is_label_q;
	logic [7:0]    left_q;
	logic [AW-1:0] fill_q;
	logic [7:0]    tally_q;

	// Output job: a run of one or more words produced by one input byte.
	logic          job_valid_q;
	logic          job_label_q;
	logic [AW-1:0] job_last_q;
	logic [7:0]    job_byte_q;
	logic          job_end_q;
	logic [7:0]    job_count_q;
	logic [AW-1:0] idx_q;

	// Hold memory and its registered read port.
	logic [7:0] hold_mem [tlvlp_pkg::HOLD_DEPTH];
	logic [7:0] rd_data_q;

	logic          at_last;
	logic          job_done;
	logic          xfer;
	logic [AW-1:0] idx_d;

	// Scan next-state values.
	logic [2:0]    magic_c, magic_n;
	logic [1:0]    phase_c, phase_n;
	logic          is_label_c, is_label_n;
	logic [7:0]    left_c, left_n;
	logic [AW-1:0] fill_c, fill_n;
	logic [7:0]    tally_c, tally_n;
	logic          new_job;
	logic          new_label;
	logic [AW-1:0] new_last;
	logic          hold_we;

	assign at_last  = (idx_q == job_last_q);
	assign job_done = job_valid_q && out_ready && at_last;
	assign xfer     = pend_valid_q && (!job_valid_q || job_done);
	assign in_ready = !pend_valid_q || xfer;

	// The read address runs one step ahead, so rd_data_q always shows the
	// entry at idx_q. Writes only happen when a job hands over, never while
	// a flush is reading.
	always_comb begin
		if (job_valid_q && out_ready && !at_last) begin
			idx_d = idx_q + 1'b1;
		end else if (job_done || !job_valid_q) begin
			idx_d = '0;
		end else begin
			idx_d = idx_q;
		end
	end

	// Per-byte scan: a first byte restarts the walk before it is looked at,
	// and a last byte returns the walk to the search state afterwards.
	always_comb begin
		logic [7:0] b;
		b = pend_q.data_byte;

		if (pend_q.first_flag) begin
			magic_c    = '0;
			phase_c    = PH_SEARCH;
			is_label_c = 1'b0;
			left_c     = '0;
			fill_c     = '0;
			tally_c    = '0;
		end else begin
			magic_c    = magic_q;
			phase_c    = phase_q;
			is_label_c = is_label_q;
			left_c     = left_q;
			fill_c     = fill_q;
			tally_c    = tally_q;
		end

		magic_n    = magic_c;
		phase_n    = phase_c;
		is_label_n = is_label_c;
		left_n     = left_c;
		fill_n     = fill_c;
		tally_n    = tally_c;
		new_job    = 1'b0;
		new_label  = 1'b0;
		new_last   = '0;
		hold_we    = 1'b0;

		case (phase_c)
			PH_SEARCH: begin
				new_job = 1'b1;
				if (b == tlvlp_pkg::magic_byte(magic_c)) begin
					if (magic_c == tlvlp_pkg::MAGIC_LAST) begin
						magic_n = '0;
						phase_n = PH_TYPE;
					end else begin
						magic_n = magic_c + 1'b1;
					end
				end else begin
					magic_n = (b == tlvlp_pkg::MAGIC_H) ? 3'd1 : 3'd0;
				end
			end
			PH_TYPE: begin
				new_job    = 1'b1;
				is_label_n = (b == tlvlp_pkg::LABEL_KIND);
				phase_n    = PH_LEN;
			end
			PH_LEN: begin
				new_job = 1'b1;
				if (b != LABEL_LEN) begin
					is_label_n = 1'b0;
				end
				// A zero-length record goes straight to the next type byte.
				if (b == 8'd0) begin
					phase_n = PH_TYPE;
				end else begin
					left_n  = b;
					fill_n  = '0;
					phase_n = PH_VALUE;
				end
			end
			default: begin
				if (is_label_c) begin
					if (left_c <= 8'd1) begin
						new_job   = 1'b1;
						new_label = 1'b1;
						new_last  = LABEL_LAST;
						if (tally_c != 8'hFF) begin
							tally_n = tally_c + 1'b1;
						end
						fill_n  = '0;
						left_n  = '0;
						phase_n = PH_TYPE;
					end else if (pend_q.last_flag) begin
						// Buffer ends inside a label value: flush it unchanged.
						new_job  = 1'b1;
						new_last = fill_c;
						fill_n   = '0;
					end else begin
						hold_we = 1'b1;
						fill_n  = fill_c + 1'b1;
						left_n  = left_c - 1'b1;
					end
				end else begin
					new_job = 1'b1;
					left_n  = (left_c != 8'd0) ? left_c - 1'b1 : 8'd0;
					if (left_c <= 8'd1) begin
						phase_n = PH_TYPE;
					end
				end
			end
		endcase

		if (pend_q.last_flag) begin
			magic_n    = '0;
			phase_n    = PH_SEARCH;
			is_label_n = 1'b0;
			left_n     = '0;
			fill_n     = '0;
			tally_n    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_lo_q <= tlvlp_pkg::LABEL_RESET;
			label_hi_q <= tlvlp_pkg::LABEL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tlvlp_pkg::CFG_LABEL_LOW:  label_lo_q <= cfg_data;
				tlvlp_pkg::CFG_LABEL_HIGH: label_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			pend_valid_q <= 1'b1;
		end else if (xfer) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pend_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q    <= '0;
			phase_q    <= PH_SEARCH;
			is_label_q <= 1'b0;
			left_q     <= '0;
			fill_q     <= '0;
			tally_q    <= '0;
		end else if (xfer) begin
			magic_q    <= magic_n;
			phase_q    <= phase_n;
			is_label_q <= is_label_n;
			left_q     <= left_n;
			fill_q     <= fill_n;
			tally_q    <= tally_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			idx_q <= idx_d;
			if (xfer) begin
				job_valid_q <= new_job;
			end else if (job_done) begin
				job_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer && new_job) begin
			job_label_q <= new_label;
			job_last_q  <= new_last;
			job_byte_q  <= pend_q.data_byte;
			job_end_q   <= pend_q.last_flag;
			job_count_q <= tally_c + 8'((new_label && tally_c != 8'hFF) ? 1 : 0);
		end
	end

	always_ff @(posedge clk) begin
		if (xfer && hold_we) begin
			hold_mem[fill_c] <= pend_q.data_byte;
		end
		rd_data_q <= hold_mem[idx_d];
	end

	// Output word: label bytes for a patch, otherwise held bytes and then the
	// byte that created the job.
	always_comb begin
		out_valid = job_valid_q;
		if (job_label_q) begin
			out_data.out_byte = tlvlp_pkg::label_byte(label_lo_q, label_hi_q, idx_q);
		end else if (at_last) begin
			out_data.out_byte = job_byte_q;
		end else begin
			out_data.out_byte = rd_data_q;
		end
		out_data.end_flag    = job_end_q && at_last;
		out_data.patch_count = (job_end_q && at_last) ? job_count_q : 8'd0;
	end

endmodule
`default_nettype wire

### hdl/tlvlp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// TLV label patcher port checker
// Concurrent checks on the top level ports, bound to the core.
// ----------------------------------------------------------------------------
module tlvlp_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        in_valid,
	input wire                        in_ready,
	input wire tlvlp_pkg::in_word_t   in_data,
	input wire                        out_valid,
	input wire                        out_ready,
	input wire tlvlp_pkg::out_word_t  out_data
);

	// A waiting input word holds its value.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input word changed while waiting");

	// A stalled output word holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// The count is only reported on the final word of a buffer.
	a_count_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.end_flag |-> out_data.patch_count == 8'd0)
		else $error("patch count on a word that does not end a buffer");

	// Input is only refused while output work is pending.
	a_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input refused with no output pending");

	// A refused input word becomes acceptable only in a cycle where output moves.
	a_ready_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && !out_ready |=> !in_ready || (out_valid && out_ready))
		else $error("input accepted although output did not move");

endmodule

bind tlv_marker_label_patcher_core tlvlp_checker u_tlvlp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire
